// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the trigger unit modules.
// Each module that uses them has ports named i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FSWHT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FSWHT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fswht_pkg.sv =====
// ----------------------------------------------------------------------------
// fswht_pkg
// Shared types and constants of the fixed-step window hit trigger unit.
// ----------------------------------------------------------------------------
package fswht_pkg;

    localparam int unsigned CAP_W = 4;
    localparam logic [CAP_W-1:0] RESULT_CAP = 4'd8;

    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HITS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HITS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_FRAC = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_STEP  = 3'd4;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;     // latch hit, open event if none
        logic scan_step;  // examine one slot for the close search
        logic pass_last;  // close search mode: last-hit pass
        logic eval;       // register total and threshold products
        logic close;      // close best slot, emit if it triggers
        logic adv_start;  // start gap advance
        logic adv_x_t;    // advance target: hit time (else hit time minus length)
        logic adv_fin;    // apply remainder to next start
        logic adv_step;   // add one step to next start
        logic alloc;      // open a window at next start
        logic update;     // count hit in all covering windows
        logic end_ev;     // drop all windows, close event
        logic flush;      // move pending result out as last of run
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_last;
        logic best_found;
        logic close_stall;
        logic a_go;
        logic loop_go;
        logic loop_far;
        logic free_any;
        logic div_busy;
        logic pend_valid;
        logic out_free;
        logic last_hit;
    } t_sts;

endpackage

// ===== hdl/fixed_step_window_hit_trigger_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_step_window_hit_trigger_unit
// Fixed-step time window trigger over the hits of one event.
// ----------------------------------------------------------------------------
// Hits enter on the input channel (valid/ready), one transaction per hit, in
// nondecreasing time order; last_in_event ends the event. Triggered windows
// leave on the output channel, up to eight per hit, the final one of each hit
// marked by last_of_run. Registers are written through the config channel,
// which is always ready; write only while the unit is idle.
// One hit at a time: each close search walks the window slots one per cycle,
// a start advance over a gap runs the remainder unit, windows are opened at
// the next start, the hit is counted in its windows, and the run ends with a
// flush. A result reaches the output one window after it is found, the last
// one at the flush. A stalled receiver holds the output register; the
// sequencer waits whenever a new result would overwrite it. Reset clears the
// event, all window slots and the output, and loads register defaults.
// ----------------------------------------------------------------------------
module fixed_step_window_hit_trigger_unit #(
    parameter int unsigned OPEN_WINDOWS = 8,
    parameter int unsigned TIME_BITS    = 32,
    parameter int unsigned COUNT_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_hit_time,
    input  logic        i_coincident,
    input  logic        i_last_in_event,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_window_start,
    output logic [31:0] o_window_end,
    output logic [15:0] o_first_hit_index,
    output logic [15:0] o_hit_count,
    output logic        o_last_of_run,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [fswht_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    fswht_pkg::t_cmd cmd;
    fswht_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    fswht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fswht_dp #(
        .N  (OPEN_WINDOWS),
        .TW (TIME_BITS),
        .CB (COUNT_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_hit_time        (i_hit_time),
        .i_coincident      (i_coincident),
        .i_last_in_event   (i_last_in_event),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_window_start    (o_window_start),
        .o_window_end      (o_window_end),
        .o_first_hit_index (o_first_hit_index),
        .o_hit_count       (o_hit_count),
        .o_last_of_run     (o_last_of_run)
    );

endmodule

// ===== hdl/fswht_rem.sv =====
// ----------------------------------------------------------------------------
// fswht_rem
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fswht_rem #(
    parameter int unsigned TW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [TW-1:0] i_dividend,
    input  logic [31:0]   i_divisor,
    output logic          o_busy,
    output logic [TW-1:0] o_rem
);
    localparam int unsigned EW = (TW > 32) ? TW : 32;
    localparam int unsigned CW = $clog2(TW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [TW-1:0] r_q;
    logic [EW-1:0] r_rem;
    logic [EW:0]   trial;
    logic [EW:0]   div_e;

    assign div_e = (EW+1)'(i_divisor);
    assign trial = {r_rem, r_q[TW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(TW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q <= {r_q[TW-2:0], 1'b0};
            if (trial >= div_e) begin
                r_rem <= EW'(trial - div_e);
            end else begin
                r_rem <= trial[EW-1:0];
            end
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem[TW-1:0];

    `FSWHT_ASSERT_IMP(a_no_restart, i_start, !r_busy, "remainder unit restarted while busy")

endmodule

// ===== hdl/fswht_dp.sv =====
// ----------------------------------------------------------------------------
// fswht_dp
// Datapath: configuration, event state, window slots, close search,
// threshold products, pending result and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fswht_dp #(
    parameter int unsigned N  = 8,
    parameter int unsigned TW = 32,
    parameter int unsigned CB = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fswht_pkg::t_cmd               i_cmd,
    output fswht_pkg::t_sts               o_sts,
    input  logic [31:0]                   i_hit_time,
    input  logic                          i_coincident,
    input  logic                          i_last_in_event,
    input  logic                          i_cfg_valid,
    input  logic [fswht_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [31:0]                   o_window_start,
    output logic [31:0]                   o_window_end,
    output logic [15:0]                   o_first_hit_index,
    output logic [15:0]                   o_hit_count,
    output logic                          o_last_of_run
);
    localparam int unsigned EW = (TW > 32) ? TW : 32;
    localparam int unsigned KW = (N > 1) ? $clog2(N) : 1;
    localparam int unsigned PW = CB + 17;

    // configuration
    logic [15:0] r_min_hits, r_max_hits, r_frac;
    logic [31:0] r_len, r_step;

    // hit and event state
    logic [TW-1:0] r_t, r_next, r_x;
    logic          r_hard, r_last, r_open, r_done, r_skip;
    logic [CB-1:0] r_hitc;
    logic [fswht_pkg::CAP_W-1:0] r_n;

    // window slots
    logic [TW-1:0] r_s_start [N];
    logic [CB-1:0] r_s_hard  [N];
    logic [CB-1:0] r_s_soft  [N];
    logic [CB-1:0] r_s_first [N];
    logic [N-1:0]  r_s_valid;

    // close search
    logic [KW-1:0] r_k, r_best;
    logic          r_best_found;
    logic [TW-1:0] r_best_s;
    logic [CB:0]   r_tot;
    logic [PW-1:0] r_lhs, r_rhs;

    // pending and output results
    logic        r_p_valid, r_o_valid;
    logic [31:0] r_p_start, r_p_end;
    logic [15:0] r_p_first, r_p_cnt;
    logic [31:0] r_o_start, r_o_end;
    logic [15:0] r_o_first, r_o_cnt;
    logic        r_o_last;

    logic [EW-1:0] len_e;
    logic [31:0]   st_eff;
    logic [TW-1:0] t_in, s_cur, x_sel, x_tl, dividend, rem;
    logic [EW-1:0] t_in_e;
    logic          cond, take, div_busy;
    logic          free_any;
    logic [KW-1:0] free_idx;
    logic [N-1:0]  in_win;
    logic [32:0]   tot_x;
    logic          trig;
    logic          out_free, load_out;
    logic [EW-1:0] start_e;
    logic [31:0]   new_start, new_end, first_x;
    logic [15:0]   new_cnt;
    logic [CB:0]   tot_cur;
    logic [PW-1:0] prod;

    assign len_e  = EW'(r_len);
    assign st_eff = (r_step == '0) ? 32'd1 : r_step;
    assign t_in_e = EW'(i_hit_time);
    assign t_in   = t_in_e[TW-1:0];
    assign s_cur  = r_s_start[r_k];

    always_comb begin
        if (i_cmd.pass_last) begin
            cond = s_cur < r_t;
        end else begin
            cond = (r_t >= s_cur) && (EW'(r_t - s_cur) >= len_e);
        end
        take = r_s_valid[r_k] && cond
            && ((r_k == '0) || !r_best_found || (s_cur < r_best_s));
    end

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int k = N - 1; k >= 0; k--) begin
            if (!r_s_valid[k]) begin
                free_any = 1'b1;
                free_idx = KW'(k);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < N; k++) begin
            in_win[k] = r_s_valid[k] && (r_t >= r_s_start[k])
                && (EW'(r_t - r_s_start[k]) < len_e);
        end
    end

    // gap advance target and divider operand
    assign x_tl     = TW'(EW'(r_t) - len_e);
    assign x_sel    = i_cmd.adv_x_t ? r_t : x_tl;
    assign dividend = (r_next <= x_sel) ? (x_sel - r_next) : '0;

    fswht_rem #(.TW(TW)) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.adv_start),
        .i_dividend (dividend),
        .i_divisor  (st_eff),
        .o_busy     (div_busy),
        .o_rem      (rem)
    );

    // threshold test on registered products
    assign tot_cur = (CB+1)'(r_s_hard[r_best]) + (CB+1)'(r_s_soft[r_best]);
    assign prod    = PW'(r_frac) * PW'(tot_cur);
    assign tot_x   = 33'(r_tot);
    assign trig    = (tot_x != '0) && (tot_x >= 33'(r_min_hits))
        && (tot_x <= 33'(r_max_hits)) && (r_lhs > r_rhs)
        && (r_n < fswht_pkg::RESULT_CAP);

    assign start_e   = EW'(r_best_s);
    assign new_start = start_e[31:0];
    assign new_end   = 32'(start_e + len_e);
    assign first_x   = 32'(r_s_first[r_best]);
    assign new_cnt   = (tot_x > 33'd65535) ? 16'hFFFF : tot_x[15:0];

    assign out_free = !r_o_valid || i_out_ready;
    assign load_out = (i_cmd.close && trig && r_p_valid) || (i_cmd.flush && r_p_valid);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_hits   <= 16'd1;
            r_max_hits   <= 16'hFFFF;
            r_frac       <= 16'd0;
            r_len        <= 32'd1000;
            r_step       <= 32'd1000;
            r_open       <= 1'b0;
            r_done       <= 1'b0;
            r_next       <= '0;
            r_hitc       <= '0;
            r_n          <= '0;
            r_s_valid    <= '0;
            r_k          <= '0;
            r_best_found <= 1'b0;
            r_p_valid    <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == fswht_pkg::REG_MIN_HITS) r_min_hits <= i_cfg_data[15:0];
                if (i_cfg_index == fswht_pkg::REG_MAX_HITS) r_max_hits <= i_cfg_data[15:0];
                if (i_cfg_index == fswht_pkg::REG_SOFT_FRAC) r_frac <= i_cfg_data[15:0];
                if (i_cfg_index == fswht_pkg::REG_WIN_LEN) r_len <= i_cfg_data;
                if (i_cfg_index == fswht_pkg::REG_WIN_STEP) r_step <= i_cfg_data;
            end

            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end

            if (i_cmd.accept) begin
                r_n <= '0;
                if (!r_open) begin
                    r_open    <= 1'b1;
                    r_next    <= t_in;
                    r_done    <= 1'b0;
                    r_hitc    <= '0;
                    r_s_valid <= '0;
                end
            end

            if (i_cmd.scan_step) begin
                r_k <= (r_k == KW'(N - 1)) ? '0 : r_k + 1'b1;
                if (r_k == '0) begin
                    r_best_found <= take;
                end else if (take) begin
                    r_best_found <= 1'b1;
                end
            end

            if (i_cmd.close) begin
                r_s_valid[r_best] <= 1'b0;
                if (trig) begin
                    r_p_valid <= 1'b1;
                    r_n       <= r_n + 1'b1;
                end
            end

            if (i_cmd.adv_fin && !r_skip) begin
                r_next <= r_x - rem;
            end

            if (i_cmd.adv_step) begin
                if (EW'(st_eff) > EW'(~r_next)) begin
                    r_done <= 1'b1;
                end else begin
                    r_next <= TW'(EW'(r_next) + EW'(st_eff));
                end
            end

            if (i_cmd.alloc) begin
                r_s_valid[free_idx] <= 1'b1;
            end

            if (i_cmd.update && (r_hitc != '1)) begin
                r_hitc <= r_hitc + 1'b1;
            end

            if (i_cmd.end_ev) begin
                r_s_valid <= '0;
                r_open    <= 1'b0;
            end

            if (i_cmd.flush) begin
                r_p_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_t    <= t_in;
            r_hard <= i_coincident;
            r_last <= i_last_in_event;
        end
        if (i_cmd.scan_step && take) begin
            r_best   <= r_k;
            r_best_s <= s_cur;
        end
        if (i_cmd.eval) begin
            r_tot <= tot_cur;
            r_lhs <= PW'({r_s_soft[r_best], 16'h0000});
            r_rhs <= prod;
        end
        if (i_cmd.adv_start) begin
            r_x    <= x_sel;
            r_skip <= r_next > x_sel;
        end
        if (i_cmd.alloc) begin
            r_s_start[free_idx] <= r_next;
            r_s_hard[free_idx]  <= '0;
            r_s_soft[free_idx]  <= '0;
            r_s_first[free_idx] <= r_hitc;
        end
        if (i_cmd.update) begin
            for (int k = 0; k < N; k++) begin
                if (in_win[k]) begin
                    if ((r_s_hard[k] == '0) && (r_s_soft[k] == '0)) begin
                        r_s_first[k] <= r_hitc;
                    end
                    if (r_hard) begin
                        if (r_s_hard[k] != '1) r_s_hard[k] <= r_s_hard[k] + 1'b1;
                    end else begin
                        if (r_s_soft[k] != '1) r_s_soft[k] <= r_s_soft[k] + 1'b1;
                    end
                end
            end
        end
        if (i_cmd.close && trig) begin
            r_p_start <= new_start;
            r_p_end   <= new_end;
            r_p_first <= first_x[15:0];
            r_p_cnt   <= new_cnt;
        end
        if (load_out) begin
            r_o_start <= r_p_start;
            r_o_end   <= r_p_end;
            r_o_first <= r_p_first;
            r_o_cnt   <= r_p_cnt;
            r_o_last  <= i_cmd.flush;
        end
    end

    always_comb begin
        o_sts             = '0;
        o_sts.scan_last   = (r_k == KW'(N - 1));
        o_sts.best_found  = r_best_found;
        o_sts.close_stall = trig && r_p_valid && !out_free;
        o_sts.a_go        = !r_done && (r_next <= r_t) && (EW'(r_t - r_next) >= len_e);
        o_sts.loop_go     = !r_done && (r_next <= r_t);
        o_sts.loop_far    = EW'(r_t - r_next) >= len_e;
        o_sts.free_any    = free_any;
        o_sts.div_busy    = div_busy;
        o_sts.pend_valid  = r_p_valid;
        o_sts.out_free    = out_free;
        o_sts.last_hit    = r_last;
    end

    assign o_out_valid       = r_o_valid;
    assign o_window_start    = r_o_start;
    assign o_window_end      = r_o_end;
    assign o_first_hit_index = r_o_first;
    assign o_hit_count       = r_o_cnt;
    assign o_last_of_run     = r_o_last;

    `FSWHT_ASSERT_IMP(a_no_overwrite, load_out, out_free, "output register overwritten")
    `FSWHT_ASSERT_IMP(a_pend_empty, i_cmd.accept, !r_p_valid, "result pending at new hit")

endmodule

// ===== hdl/fswht_ctrl.sv =====
// ----------------------------------------------------------------------------
// fswht_ctrl
// Sequencer for one hit: early close, start advance, window open, count,
// final close at the last hit of an event and flush of the last result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fswht_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  fswht_pkg::t_sts i_sts,
    output fswht_pkg::t_cmd o_cmd
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_SCAN  = 11'b00000000010,
        S_EVAL  = 11'b00000000100,
        S_CLOSE = 11'b00000001000,
        S_CHKA  = 11'b00000010000,
        S_ADVW  = 11'b00000100000,
        S_ADVS  = 11'b00001000000,
        S_LOOP  = 11'b00010000000,
        S_UPD   = 11'b00100000000,
        S_ENDEV = 11'b01000000000,
        S_FLUSH = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_pass, n_pass;
    logic   r_ret_upd, n_ret_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pass    <= 1'b0;
            r_ret_upd <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pass    <= n_pass;
            r_ret_upd <= n_ret_upd;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_pass          = r_pass;
        n_ret_upd       = r_ret_upd;
        o_cmd           = '0;
        o_cmd.pass_last = r_pass;
        o_in_ready      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_pass       = 1'b0;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.best_found) begin
                    o_cmd.eval = 1'b1;
                    n_state    = S_CLOSE;
                end else if (r_pass) begin
                    n_state = S_ENDEV;
                end else begin
                    n_state = S_CHKA;
                end
            end
            S_CLOSE: begin
                // hold while an earlier result still blocks the output
                if (!i_sts.close_stall) begin
                    o_cmd.close = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_CHKA: begin
                if (i_sts.a_go) begin
                    o_cmd.adv_start = 1'b1;
                    n_ret_upd       = 1'b0;
                    n_state         = S_ADVW;
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_ADVW: begin
                if (!i_sts.div_busy) begin
                    o_cmd.adv_fin = 1'b1;
                    n_state       = S_ADVS;
                end
            end
            S_ADVS: begin
                o_cmd.adv_step = 1'b1;
                n_state        = r_ret_upd ? S_UPD : S_LOOP;
            end
            S_LOOP: begin
                if (!i_sts.loop_go) begin
                    n_state = S_UPD;
                end else if (i_sts.loop_far || !i_sts.free_any) begin
                    o_cmd.adv_start = 1'b1;
                    o_cmd.adv_x_t   = 1'b1;
                    n_ret_upd       = 1'b1;
                    n_state         = S_ADVW;
                end else begin
                    o_cmd.alloc    = 1'b1;
                    o_cmd.adv_step = 1'b1;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                if (i_sts.last_hit) begin
                    n_pass  = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_ENDEV: begin
                o_cmd.end_ev = 1'b1;
                n_state      = S_FLUSH;
            end
            S_FLUSH: begin
                if (!i_sts.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `FSWHT_ASSERT_NXT(a_acc_scan, i_in_valid && o_in_ready, r_state == S_SCAN,
        "accepted hit did not start the close search")

endmodule
